// ----- design/assert_macros.svh -----
// assertion helpers for the root finder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- design/cbrf_pkg.sv -----
`default_nettype none

package cbrf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IN_W          = 24;
    localparam int TOL_W         = 23;
    localparam int LIM_W         = 10;
    localparam int CNT_W         = 11;
    localparam int CFG_IDX_W     = 2;
    localparam int PC_W          = 4;
    localparam int POLY_LIN      = 9;
    localparam int POLY_CONST    = 3;

    localparam logic [TOL_W-1:0] RESET_TOLERANCE  = TOL_W'(66);
    localparam logic [LIM_W-1:0] RESET_ITER_LIMIT = LIM_W'(1000);
    localparam logic [LIM_W-1:0] ITER_SAT         = {LIM_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = CFG_IDX_W'(1);

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_SIGN = 1'b1;

    // microprogram step addresses
    localparam logic [PC_W-1:0] PC_SQ_A    = PC_W'(0);
    localparam logic [PC_W-1:0] PC_CU_A    = PC_W'(1);
    localparam logic [PC_W-1:0] PC_FIN_A   = PC_W'(2);
    localparam logic [PC_W-1:0] PC_SQ_B    = PC_W'(3);
    localparam logic [PC_W-1:0] PC_CU_B    = PC_W'(4);
    localparam logic [PC_W-1:0] PC_FIN_B   = PC_W'(5);
    localparam logic [PC_W-1:0] PC_CHECK   = PC_W'(6);
    localparam logic [PC_W-1:0] PC_SQ_M    = PC_W'(7);
    localparam logic [PC_W-1:0] PC_CU_M    = PC_W'(8);
    localparam logic [PC_W-1:0] PC_FIN_M   = PC_W'(9);
    localparam logic [PC_W-1:0] PC_TEST    = PC_W'(10);
    localparam logic [PC_W-1:0] PC_ROOT    = PC_W'(11);
    localparam logic [PC_W-1:0] PC_INVALID = PC_W'(12);

    typedef struct packed {
        logic signed [IN_W-1:0] lower_bound;
        logic signed [IN_W-1:0] upper_bound;
    } req_word_t;

    typedef struct packed {
        logic signed [IN_W-1:0] root_estimate;
        logic [LIM_W-1:0]       iterations_used;
        logic                   status;
    } rsp_word_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_SQUARE,
        MUL_CUBE
    } mul_op_t;

    typedef enum logic [1:0] {
        FD_NONE,
        FD_FA,
        FD_FM
    } f_dst_t;

    typedef enum logic [1:0] {
        XS_HOLD,
        XS_UPPER,
        XS_MID
    } x_sel_t;

    typedef enum logic [1:0] {
        C_NEVER,
        C_NO_CHANGE,
        C_STOP
    } cond_t;

    typedef enum logic [1:0] {
        FIN_NONE,
        FIN_ROOT,
        FIN_INVALID
    } fin_t;

    typedef struct packed {
        mul_op_t         mul;
        f_dst_t          fdst;
        x_sel_t          xsel;
        logic            upd;
        cond_t           cond;
        logic [PC_W-1:0] tgt;
        logic [PC_W-1:0] nxt;
        fin_t            fin;
    } ucode_word_t;

    typedef struct packed {
        logic no_change;
        logic stop;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- design/cbrf_ucode_rom.sv -----
`default_nettype none

module cbrf_ucode_rom (
    input  wire logic [cbrf_pkg::PC_W-1:0] pc,
    output cbrf_pkg::ucode_word_t          word
);

    always_comb
    begin
        word      = '0;
        word.mul  = cbrf_pkg::MUL_NONE;
        word.fdst = cbrf_pkg::FD_NONE;
        word.xsel = cbrf_pkg::XS_HOLD;
        word.cond = cbrf_pkg::C_NEVER;
        word.fin  = cbrf_pkg::FIN_NONE;
        unique case (pc)
            cbrf_pkg::PC_SQ_A:
            begin
                word.mul = cbrf_pkg::MUL_SQUARE;
                word.nxt = cbrf_pkg::PC_CU_A;
            end
            cbrf_pkg::PC_CU_A:
            begin
                word.mul = cbrf_pkg::MUL_CUBE;
                word.nxt = cbrf_pkg::PC_FIN_A;
            end
            cbrf_pkg::PC_FIN_A:
            begin
                word.fdst = cbrf_pkg::FD_FA;
                word.xsel = cbrf_pkg::XS_UPPER;
                word.nxt  = cbrf_pkg::PC_SQ_B;
            end
            cbrf_pkg::PC_SQ_B:
            begin
                word.mul = cbrf_pkg::MUL_SQUARE;
                word.nxt = cbrf_pkg::PC_CU_B;
            end
            cbrf_pkg::PC_CU_B:
            begin
                word.mul = cbrf_pkg::MUL_CUBE;
                word.nxt = cbrf_pkg::PC_FIN_B;
            end
            cbrf_pkg::PC_FIN_B:
            begin
                word.fdst = cbrf_pkg::FD_FM;
                word.nxt  = cbrf_pkg::PC_CHECK;
            end
            cbrf_pkg::PC_CHECK:
            begin
                word.xsel = cbrf_pkg::XS_MID;
                word.cond = cbrf_pkg::C_NO_CHANGE;
                word.tgt  = cbrf_pkg::PC_INVALID;
                word.nxt  = cbrf_pkg::PC_SQ_M;
            end
            cbrf_pkg::PC_SQ_M:
            begin
                word.mul = cbrf_pkg::MUL_SQUARE;
                word.nxt = cbrf_pkg::PC_CU_M;
            end
            cbrf_pkg::PC_CU_M:
            begin
                word.mul = cbrf_pkg::MUL_CUBE;
                word.nxt = cbrf_pkg::PC_FIN_M;
            end
            cbrf_pkg::PC_FIN_M:
            begin
                word.fdst = cbrf_pkg::FD_FM;
                word.nxt  = cbrf_pkg::PC_TEST;
            end
            cbrf_pkg::PC_TEST:
            begin
                // interval update happens only when the stop test fails
                word.upd  = 1'b1;
                word.cond = cbrf_pkg::C_STOP;
                word.tgt  = cbrf_pkg::PC_ROOT;
                word.nxt  = cbrf_pkg::PC_SQ_M;
            end
            cbrf_pkg::PC_ROOT:
            begin
                word.fin = cbrf_pkg::FIN_ROOT;
            end
            default:
            begin
                word.fin = cbrf_pkg::FIN_INVALID;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/cbrf_datapath.sv -----
`default_nettype none

module cbrf_datapath #(
    parameter int FRAC_BITS = cbrf_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          load,
    input  wire cbrf_pkg::req_word_t           req,
    input  wire cbrf_pkg::ucode_word_t         cw,
    input  wire logic [cbrf_pkg::TOL_W-1:0]    tolerance,
    input  wire logic [cbrf_pkg::LIM_W-1:0]    iteration_limit,
    output cbrf_pkg::dp_status_t               status,
    output logic signed [cbrf_pkg::IN_W-1:0]   mid,
    output logic [cbrf_pkg::CNT_W-1:0]         count
);

    localparam int XW  = cbrf_pkg::IN_W;
    localparam int SQW = 2 * XW;
    localparam int X2W = SQW - FRAC_BITS;
    localparam int PW  = X2W + XW;
    localparam int X3W = PW - FRAC_BITS;
    localparam int FMIN = XW + 5;
    localparam int FW  = ((X3W > FMIN) ? X3W : FMIN) + 1;

    logic signed [XW-1:0]  a_reg, a_next;
    logic signed [XW-1:0]  b_reg, b_next;
    logic signed [XW-1:0]  x_reg, x_next;
    logic signed [XW-1:0]  mid_reg, mid_next;
    logic signed [PW-1:0]  prod_reg, prod_next;
    logic signed [FW-1:0]  fa_reg, fa_next;
    logic signed [FW-1:0]  fm_reg, fm_next;
    logic [cbrf_pkg::CNT_W-1:0] count_reg, count_next;

    logic signed [X2W-1:0] mul_a;
    logic signed [X3W-1:0] x3;
    logic signed [FW-1:0]  f_val;
    logic signed [FW-1:0]  lin_coef;
    logic signed [FW-1:0]  const_term;
    logic signed [FW-1:0]  tol_s;
    logic signed [XW:0]    diff;
    logic [XW:0]           width_abs;
    logic                  sign_chg;
    logic                  stop;
    logic                  go_upd;
    logic signed [XW-1:0]  na, nb;
    logic signed [XW:0]    mid_sum;

    // shared multiplier: square of x, then floor(x^2) times x
    always_comb
    begin
        unique case (cw.mul)
            cbrf_pkg::MUL_CUBE: mul_a = prod_reg[SQW-1:FRAC_BITS];
            default:            mul_a = X2W'(x_reg);
        endcase
        prod_next = PW'(mul_a) * PW'(x_reg);
    end

    assign lin_coef   = FW'(cbrf_pkg::POLY_LIN);
    assign const_term = FW'(cbrf_pkg::POLY_CONST) <<< FRAC_BITS;
    assign x3         = prod_reg[PW-1:FRAC_BITS];
    assign f_val      = FW'(x3) - FW'(x_reg) * lin_coef + const_term;

    assign sign_chg = (fa_reg < 0 && fm_reg > 0) || (fa_reg > 0 && fm_reg < 0);

    assign diff      = (XW+1)'(b_reg) - (XW+1)'(a_reg);
    assign width_abs = diff[XW] ? (XW+1)'(0) - diff : diff;
    assign tol_s     = FW'({1'b0, tolerance});

    assign stop = (width_abs <= (XW+1)'(tolerance))
                || (fm_reg < tol_s && fm_reg > -tol_s)
                || (count_reg > {1'b0, iteration_limit});

    assign go_upd = cw.upd && !stop;

    // next interval and its midpoint
    always_comb
    begin
        na = a_reg;
        nb = b_reg;
        if (go_upd)
        begin
            if (sign_chg)
            begin
                nb = mid_reg;
            end
            else
            begin
                na = mid_reg;
            end
        end
        mid_sum = (XW+1)'(na) + (XW+1)'(nb);
    end

    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        x_next     = x_reg;
        mid_next   = mid_reg;
        fa_next    = fa_reg;
        fm_next    = fm_reg;
        count_next = count_reg;
        if (load)
        begin
            a_next     = req.lower_bound;
            b_next     = req.upper_bound;
            x_next     = req.lower_bound;
            count_next = cbrf_pkg::CNT_W'(1);
        end
        else
        begin
            unique case (cw.fdst)
                cbrf_pkg::FD_FA: fa_next = f_val;
                cbrf_pkg::FD_FM: fm_next = f_val;
                default: ;
            endcase
            unique case (cw.xsel)
                cbrf_pkg::XS_UPPER: x_next = b_reg;
                cbrf_pkg::XS_MID:
                begin
                    x_next   = mid_sum[XW:1];
                    mid_next = mid_sum[XW:1];
                end
                default: ;
            endcase
            if (go_upd)
            begin
                a_next     = na;
                b_next     = nb;
                x_next     = mid_sum[XW:1];
                mid_next   = mid_sum[XW:1];
                count_next = count_reg + cbrf_pkg::CNT_W'(1);
                if (!sign_chg)
                begin
                    fa_next = fm_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        x_reg     <= x_next;
        mid_reg   <= mid_next;
        fa_reg    <= fa_next;
        fm_reg    <= fm_next;
        count_reg <= count_next;
        if (cw.mul != cbrf_pkg::MUL_NONE)
        begin
            prod_reg <= prod_next;
        end
    end

    assign status.no_change = !sign_chg;
    assign status.stop      = stop;
    assign mid              = mid_reg;
    assign count            = count_reg;

endmodule

`default_nettype wire

// ----- design/cubic_bisection_root_finder_core.sv -----
`default_nettype none

// Bisection search for a root of x^3 - 9x + 3 over [lower_bound, upper_bound] in signed
// fixed point with FRAC_BITS fraction bits. A small microprogram drives one shared
// multiplier: each cubic evaluation runs a square, a cube and a combine step, and
// each bisection step evaluates the midpoint, then does the stop test and interval halving.
// An accepted word first evaluates both ends and ends there when they show no sign
// change, else runs one bisection step per iteration (Q7.16 at the default FRAC_BITS).
// One result word per request; the request side is ready again as soon
// as the result is in the output register, and a result still held by the receiver
// stalls the next search at its last step. Configuration writes are taken at any
// time but must only be issued while the block is idle.
module cubic_bisection_root_finder_core #(
    parameter int FRAC_BITS = cbrf_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire cbrf_pkg::req_word_t               req,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output cbrf_pkg::rsp_word_t                    rsp,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cbrf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cbrf_pkg::TOL_W-1:0]        cfg_data
);

`include "assert_macros.svh"

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t                         state_reg, state_next;
    logic [cbrf_pkg::PC_W-1:0]      pc_reg, pc_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    cbrf_pkg::rsp_word_t            rsp_reg, rsp_next;
    logic [cbrf_pkg::TOL_W-1:0]     tol_reg, tol_next;
    logic [cbrf_pkg::LIM_W-1:0]     lim_reg, lim_next;

    cbrf_pkg::ucode_word_t          rom_word;
    cbrf_pkg::ucode_word_t          cw;
    cbrf_pkg::dp_status_t           dp_status;
    logic signed [cbrf_pkg::IN_W-1:0] dp_mid;
    logic [cbrf_pkg::CNT_W-1:0]     dp_count;
    logic                           accept;
    logic                           cond_true;
    logic                           rsp_free;

    cbrf_ucode_rom u_rom (
        .pc   (pc_reg),
        .word (rom_word)
    );

    always_comb
    begin
        cw = rom_word;
        if (state_reg != S_RUN)
        begin
            cw.mul  = cbrf_pkg::MUL_NONE;
            cw.fdst = cbrf_pkg::FD_NONE;
            cw.xsel = cbrf_pkg::XS_HOLD;
            cw.upd  = 1'b0;
            cw.cond = cbrf_pkg::C_NEVER;
            cw.fin  = cbrf_pkg::FIN_NONE;
        end
    end

    assign accept = req_valid && req_ready;

    cbrf_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk             (clk),
        .load            (accept),
        .req             (req),
        .cw              (cw),
        .tolerance       (tol_reg),
        .iteration_limit (lim_reg),
        .status          (dp_status),
        .mid             (dp_mid),
        .count           (dp_count)
    );

    always_comb
    begin
        unique case (cw.cond)
            cbrf_pkg::C_NO_CHANGE: cond_true = dp_status.no_change;
            cbrf_pkg::C_STOP:      cond_true = dp_status.stop;
            default:               cond_true = 1'b0;
        endcase
    end

    assign rsp_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        tol_next       = tol_reg;
        lim_next       = lim_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                cbrf_pkg::CFG_TOLERANCE:  tol_next = cfg_data;
                cbrf_pkg::CFG_ITER_LIMIT: lim_next = cfg_data[cbrf_pkg::LIM_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                    pc_next    = cbrf_pkg::PC_SQ_A;
                end
            end
            S_RUN:
            begin
                unique case (cw.fin)
                    cbrf_pkg::FIN_ROOT:
                    begin
                        if (rsp_free)
                        begin
                            rsp_next.root_estimate = dp_mid;
                            if (dp_count > cbrf_pkg::CNT_W'(cbrf_pkg::ITER_SAT))
                            begin
                                rsp_next.iterations_used = cbrf_pkg::ITER_SAT;
                            end
                            else
                            begin
                                rsp_next.iterations_used = dp_count[cbrf_pkg::LIM_W-1:0];
                            end
                            rsp_next.status = cbrf_pkg::STATUS_OK;
                            rsp_valid_next  = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                    cbrf_pkg::FIN_INVALID:
                    begin
                        if (rsp_free)
                        begin
                            rsp_next.root_estimate   = '0;
                            rsp_next.iterations_used = '0;
                            rsp_next.status          = cbrf_pkg::STATUS_NO_SIGN;
                            rsp_valid_next           = 1'b1;
                            state_next               = S_IDLE;
                        end
                    end
                    default:
                    begin
                        pc_next = cond_true ? cw.tgt : cw.nxt;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= cbrf_pkg::PC_SQ_A;
            rsp_valid_reg <= 1'b0;
            tol_reg       <= cbrf_pkg::RESET_TOLERANCE;
            lim_reg       <= cbrf_pkg::RESET_ITER_LIMIT;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            rsp_valid_reg <= rsp_valid_next;
            tol_reg       <= tol_next;
            lim_reg       <= lim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_NEXT(a_accept_busy, clk, rst_n, req_valid && req_ready, !req_ready,
        "accepted word did not start a search")
    `ASSERT_IMPL(a_invalid_zero, clk, rst_n,
        rsp_valid && rsp.status == cbrf_pkg::STATUS_NO_SIGN,
        rsp.root_estimate == '0 && rsp.iterations_used == '0,
        "invalid interval result not cleared")
    `ASSERT_IMPL(a_valid_count, clk, rst_n,
        rsp_valid && rsp.status == cbrf_pkg::STATUS_OK, rsp.iterations_used != '0,
        "root result with zero iterations")
    `ASSERT_IMPL(a_pc_range, clk, rst_n, state_reg == S_RUN,
        pc_reg <= cbrf_pkg::PC_INVALID, "step counter outside the program")

endmodule

`default_nettype wire

// ----- tb/sv/tb_cubic_bisection_root_finder_core.sv -----
`timescale 1ns / 100ps

module tb_cubic_bisection_root_finder_core;

    localparam int     FRAC           = cbrf_pkg::FRAC_BITS_DEF;
    localparam int     IN_W           = cbrf_pkg::IN_W;
    localparam int     TOL_W          = cbrf_pkg::TOL_W;
    localparam int     LIM_W          = cbrf_pkg::LIM_W;
    localparam int     CFG_IDX_W      = cbrf_pkg::CFG_IDX_W;
    localparam longint BOUND_MAX      = (longint'(1) <<< (IN_W - 1)) - 1;
    localparam longint BOUND_MIN      = -(longint'(1) <<< (IN_W - 1));
    localparam int     WATCHDOG_LIMIT = 20000;
    localparam int     HOLD_AT        = 100;
    localparam int     HOLD_CYCLES    = 600;
    localparam int     RANDOM_PHASES  = 6;
    localparam int     PHASE_ITEMS    = 120;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    cbrf_pkg::req_word_t  req = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    cbrf_pkg::rsp_word_t  rsp;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TOL_W-1:0]     cfg_data = '0;

    // predictor copy of the registers
    logic [TOL_W-1:0] tolerance_q = cbrf_pkg::RESET_TOLERANCE;
    logic [LIM_W-1:0] limit_q = cbrf_pkg::RESET_ITER_LIMIT;

    cbrf_pkg::req_word_t pending_bounds [$];
    cbrf_pkg::rsp_word_t expected_roots [$];
    cbrf_pkg::rsp_word_t want;

    longint bracket_at [3];
    longint root_guess [3];
    longint zero_at = 0;
    bit     zero_found = 1'b0;

    bit  steady = 1'b0;
    bit  bounds_taken = 1'b0;
    bit  result_taken = 1'b0;
    bit  reg_written = 1'b0;
    int  req_idle = 0;
    int  rsp_idle = 0;
    int  items_issued = 0;
    int  words_checked = 0;
    int  errors = 0;
    int  no_sign_words = 0;
    int  deepest = 0;
    int  reg_writes = 0;
    int  quiet_cycles = 0;

    cubic_bisection_root_finder_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic longint cubic_at(longint x);
        longint sq;
        longint cu;
        sq = (x * x) >>> FRAC;
        cu = (sq * x) >>> FRAC;
        return cu - longint'(cbrf_pkg::POLY_LIN) * x
               + (longint'(cbrf_pkg::POLY_CONST) <<< FRAC);
    endfunction

    function automatic bit opposite_signs(longint fa, longint fb);
        return (fa < 0 && fb > 0) || (fa > 0 && fb < 0);
    endfunction

    function automatic cbrf_pkg::rsp_word_t bisect_cubic(cbrf_pkg::req_word_t w);
        longint              a;
        longint              b;
        longint              mid;
        longint              fm;
        longint              width;
        longint              mag;
        int unsigned         count;
        bit                  done;
        cbrf_pkg::rsp_word_t r;
        a = longint'($signed(w.lower_bound));
        b = longint'($signed(w.upper_bound));
        r = '0;
        if (!opposite_signs(cubic_at(a), cubic_at(b)))
        begin
            r.status = cbrf_pkg::STATUS_NO_SIGN;
            return r;
        end
        count = 1;
        mid = 0;
        done = 1'b0;
        while (!done)
        begin
            mid = (a + b) >>> 1;
            fm = cubic_at(mid);
            width = (b >= a) ? (b - a) : (a - b);
            mag = (fm < 0) ? -fm : fm;
            if (width <= longint'(tolerance_q) || mag < longint'(tolerance_q) ||
                count > limit_q)
            begin
                done = 1'b1;
            end
            else
            begin
                if (opposite_signs(cubic_at(a), fm))
                    b = mid;
                else
                    a = mid;
                count++;
            end
        end
        r.root_estimate = mid[IN_W-1:0];
        r.iterations_used = (count > cbrf_pkg::ITER_SAT) ? cbrf_pkg::ITER_SAT
                                                         : count[LIM_W-1:0];
        r.status = cbrf_pkg::STATUS_OK;
        return r;
    endfunction

    function automatic logic signed [IN_W-1:0] to_bound(longint v);
        if (v > BOUND_MAX)
            v = BOUND_MAX;
        if (v < BOUND_MIN)
            v = BOUND_MIN;
        return v[IN_W-1:0];
    endfunction

    function automatic cbrf_pkg::req_word_t span_word(longint lo, longint hi);
        cbrf_pkg::req_word_t w;
        w.lower_bound = to_bound(lo);
        w.upper_bound = to_bound(hi);
        return w;
    endfunction

    function automatic longint draw_span();
        case ($urandom_range(0, 2))
            0: return longint'($urandom_range(0, 64));
            1: return longint'($urandom_range(0, 65536));
            default: return longint'($urandom_range(0, 4000000));
        endcase
    endfunction

    function automatic cbrf_pkg::req_word_t make_bounds();
        longint lo;
        longint hi;
        longint t;
        int     pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            // well-formed interval around one of the three roots
            lo = bracket_at[$urandom_range(0, 2)];
            hi = lo + 1 + draw_span();
            lo = lo - draw_span();
        end
        else if (pick < 75)
        begin
            lo = longint'($urandom_range(0, 524288)) - 262144;
            hi = longint'($urandom_range(0, 524288)) - 262144;
        end
        else if (pick < 92)
        begin
            lo = longint'($urandom_range(0, 16777215)) + BOUND_MIN;
            hi = longint'($urandom_range(0, 16777215)) + BOUND_MIN;
        end
        else
        begin
            // empty or one-wide interval
            if ($urandom_range(0, 1) == 0)
                lo = bracket_at[$urandom_range(0, 2)] + longint'($urandom_range(0, 8)) - 4;
            else
                lo = longint'($urandom_range(0, 16777215)) + BOUND_MIN;
            hi = lo + longint'($urandom_range(0, 2)) - 1;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            t = lo;
            lo = hi;
            hi = t;
        end
        return span_word(lo, hi);
    endfunction

    task automatic push_bounds(cbrf_pkg::req_word_t w);
        pending_bounds.push_back(w);
        items_issued++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TOL_W-1:0] data);
        @(negedge clk);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        reg_written = 1'b0;
        do
            @(negedge clk);
        while (!reg_written);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        while (words_checked != items_issued)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    // sender
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (bounds_taken || !req_valid)
            begin
                bounds_taken = 1'b0;
                if (req_idle > 0)
                begin
                    req_valid <= 1'b0;
                    req_idle--;
                end
                else if (pending_bounds.size() != 0)
                begin
                    req <= pending_bounds.pop_front();
                    req_valid <= 1'b1;
                    req_idle = steady ? 0 : $urandom_range(0, 8);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
            begin
                result_taken = 1'b0;
                rsp_idle = steady ? 0 : $urandom_range(0, 8);
                if (words_checked == HOLD_AT)
                    rsp_idle = HOLD_CYCLES;
            end
            if (rsp_idle > 0)
            begin
                rsp_ready <= 1'b0;
                rsp_idle--;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                reg_written = 1'b1;
                reg_writes++;
                case (cfg_index)
                    cbrf_pkg::CFG_TOLERANCE:  tolerance_q = cfg_data;
                    cbrf_pkg::CFG_ITER_LIMIT: limit_q = cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (req_valid && req_ready)
            begin
                bounds_taken = 1'b1;
                expected_roots.push_back(bisect_cubic(req));
            end
            if (rsp_valid && rsp_ready)
            begin
                result_taken = 1'b1;
                words_checked++;
                if (expected_roots.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with nothing expected: %p", $realtime, rsp);
                end
                else
                begin
                    want = expected_roots.pop_front();
                    if (rsp.root_estimate !== want.root_estimate)
                    begin
                        errors++;
                        $display("%0t: root_estimate expected %0d got %0d", $realtime,
                                 want.root_estimate, rsp.root_estimate);
                    end
                    if (rsp.iterations_used !== want.iterations_used)
                    begin
                        errors++;
                        $display("%0t: iterations_used expected %0d got %0d", $realtime,
                                 want.iterations_used, rsp.iterations_used);
                    end
                    if (rsp.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d got %0d", $realtime,
                                 want.status, rsp.status);
                    end
                    if (want.status == cbrf_pkg::STATUS_NO_SIGN)
                        no_sign_words++;
                    if (int'(want.iterations_used) > deepest)
                        deepest = want.iterations_used;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
                $display("tb_cubic_bisection_root_finder_core NOT OK");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        longint           x;
        longint           f0;
        longint           f1;
        logic [TOL_W-1:0] tol_pick;
        logic [LIM_W-1:0] lim_pick;
        logic [TOL_W-1:0] lim_word;

        // locate a one-wide bracket next to each root
        root_guess[0] = -206733;
        root_guess[1] = 22125;
        root_guess[2] = 184608;
        for (int k = 0; k < 3; k++)
        begin
            bracket_at[k] = root_guess[k];
            for (x = root_guess[k] - 4000; x <= root_guess[k] + 4000; x++)
            begin
                f0 = cubic_at(x);
                f1 = cubic_at(x + 1);
                if (opposite_signs(f0, f1))
                    bracket_at[k] = x;
                if (f0 == 0)
                begin
                    zero_at = x;
                    zero_found = 1'b1;
                end
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // reset settings
        push_bounds(span_word(BOUND_MIN, BOUND_MAX));
        push_bounds(span_word(BOUND_MAX, BOUND_MIN));
        push_bounds(span_word(BOUND_MIN, BOUND_MIN));
        push_bounds(span_word(BOUND_MAX, BOUND_MAX));
        push_bounds(span_word(0, 0));
        push_bounds(span_word(-262144, 262144));
        push_bounds(span_word(0, 262144));
        for (int k = 0; k < 3; k++)
            push_bounds(span_word(bracket_at[k] - 65536, bracket_at[k] + 65537));
        push_bounds(span_word(bracket_at[1] + 65537, bracket_at[1] - 65536));
        push_bounds(span_word(bracket_at[2], bracket_at[2] + 1));
        push_bounds(span_word(5592405, -5592406));
        push_bounds(span_word(-5592406, 5592405));
        if (zero_found)
        begin
            push_bounds(span_word(zero_at, zero_at + 65536));
            push_bounds(span_word(zero_at - 65536, zero_at));
        end
        drain();

        // zero tolerance: only the limit ends the search, one-wide brackets stick
        write_reg(cbrf_pkg::CFG_TOLERANCE, '0);
        write_reg(cbrf_pkg::CFG_ITER_LIMIT, TOL_W'(20));
        @(posedge clk);
        for (int k = 0; k < 3; k++)
            push_bounds(span_word(bracket_at[k], bracket_at[k] + 1));
        push_bounds(span_word(bracket_at[0] + 1, bracket_at[0]));
        push_bounds(span_word(bracket_at[1] - 300, bracket_at[1] + 500));
        drain();

        write_reg(cbrf_pkg::CFG_ITER_LIMIT, '0);
        @(posedge clk);
        push_bounds(span_word(bracket_at[2] - 1000, bracket_at[2] + 1000));
        push_bounds(span_word(BOUND_MIN, BOUND_MAX));
        push_bounds(span_word(0, 0));
        drain();

        // count saturation
        write_reg(cbrf_pkg::CFG_ITER_LIMIT, TOL_W'(cbrf_pkg::ITER_SAT));
        @(posedge clk);
        push_bounds(span_word(bracket_at[0] - 4096, bracket_at[0] + 4096));
        drain();

        write_reg(cbrf_pkg::CFG_TOLERANCE, '1);
        write_reg(cbrf_pkg::CFG_ITER_LIMIT, TOL_W'(cbrf_pkg::RESET_ITER_LIMIT));
        @(posedge clk);
        push_bounds(span_word(BOUND_MIN, BOUND_MAX));
        push_bounds(span_word(bracket_at[1] - 65536, bracket_at[1] + 65536));
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(0, 3))
                0: tol_pick = TOL_W'($urandom_range(1, 200));
                1: tol_pick = cbrf_pkg::RESET_TOLERANCE;
                2: tol_pick = TOL_W'($urandom_range(200, 100000));
                default: tol_pick = TOL_W'($urandom_range(1, 8388607));
            endcase
            lim_pick = ($urandom_range(0, 2) == 0) ? cbrf_pkg::RESET_ITER_LIMIT
                                                   : LIM_W'($urandom_range(0, 1000));
            lim_word = {TOL_W{1'b0}};
            if ($urandom_range(0, 1) == 0)
                lim_word = TOL_W'($urandom);
            lim_word[LIM_W-1:0] = lim_pick;
            write_reg(cbrf_pkg::CFG_TOLERANCE, tol_pick);
            write_reg(cbrf_pkg::CFG_ITER_LIMIT, lim_word);
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                          TOL_W'($urandom));
            @(posedge clk);
            steady = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) push_bounds(make_bounds());
            drain();
        end

        repeat (40) @(negedge clk);

        $display("%0d result words checked, %0d with no sign change, deepest search %0d",
                 words_checked, no_sign_words, deepest);
        $display("%0d register writes, tolerance 0 to full scale, limit 0 to saturation",
                 reg_writes);
        if (errors == 0 && expected_roots.size() == 0)
            $display("tb_cubic_bisection_root_finder_core OK");
        else
            $display("tb_cubic_bisection_root_finder_core NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/cbrf_pkg.sv
design/cbrf_ucode_rom.sv
design/cbrf_datapath.sv
design/cubic_bisection_root_finder_core.sv
tb/sv/tb_cubic_bisection_root_finder_core.sv
